// ===== design/ctw_pkg.sv =====
`timescale 1ns / 1ps
package ctw_pkg;

	// Screen geometry
	localparam int COLUMNS   = 80;
	localparam int ROWS      = 25;
	localparam int TAB_WIDTH = 4;
	localparam int CELLS     = ROWS * COLUMNS;

	localparam int COL_W  = $clog2(COLUMNS);
	localparam int ROW_W  = $clog2(ROWS);
	localparam int ADDR_W = $clog2(CELLS);
	localparam int SUM_W  = COL_W + 5;

	// Fixed widths of the channel fields
	localparam int FUNC_FW = 2;
	localparam int CHAR_FW = 8;
	localparam int IDX_FW  = 11;
	localparam int POS_FW  = 11;
	localparam int COL_FW  = 7;
	localparam int ROW_FW  = 5;
	localparam int ATTR_FW = 8;

	localparam logic [CHAR_FW-1:0] CH_TAB   = 8'h09;
	localparam logic [CHAR_FW-1:0] CH_LF    = 8'h0A;
	localparam logic [CHAR_FW-1:0] CH_CR    = 8'h0D;
	localparam logic [CHAR_FW-1:0] CH_SPACE = 8'h20;
	localparam logic [ATTR_FW-1:0] RESET_ATTR = 8'h0F;

	typedef enum logic [FUNC_FW-1:0] {
		FUNC_PUT   = 2'd0,
		FUNC_BKSP  = 2'd1,
		FUNC_CLEAR = 2'd2,
		FUNC_READ  = 2'd3
	} func_t;

	typedef struct packed {
		logic in_ready;
		logic take_in;
		logic exec;
		logic scroll_go;
		logic fill_go;
		logic sweep_run;
		logic load_out;
	} ctw_cmd_t;

	typedef struct packed {
		func_t func;
		logic  need_scroll;
		logic  sweep_last;
		logic  out_free;
	} ctw_stat_t;

endpackage

// ===== design/ctw_if.sv =====
`timescale 1ns / 1ps
interface ctw_req_if import ctw_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [FUNC_FW-1:0]  func;
	logic [CHAR_FW-1:0]  char_code;
	logic [IDX_FW-1:0]   cell_index;

	modport source (output valid, output func, output char_code, output cell_index,
		input ready);
	modport sink (input valid, input func, input char_code, input cell_index,
		output ready);
endinterface

interface ctw_rsp_if import ctw_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [POS_FW-1:0]  cursor_pos;
	logic [COL_FW-1:0]  cursor_col;
	logic [ROW_FW-1:0]  cursor_row;
	logic               scrolled;
	logic [CHAR_FW-1:0] read_char;
	logic [ATTR_FW-1:0] read_attr;

	modport source (output valid, output cursor_pos, output cursor_col,
		output cursor_row, output scrolled, output read_char, output read_attr,
		input ready);
	modport sink (input valid, input cursor_pos, input cursor_col,
		input cursor_row, input scrolled, input read_char, input read_attr,
		output ready);
endinterface

// ===== design/ctw_ctrl.sv =====
`timescale 1ns / 1ps
module ctw_ctrl import ctw_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  ctw_stat_t stat,
	output ctw_cmd_t  cmd
);

	typedef enum logic [5:0] {
		S_INIT   = 6'b000001,
		S_IDLE   = 6'b000010,
		S_EXEC   = 6'b000100,
		S_SCROLL = 6'b001000,
		S_FILL   = 6'b010000,
		S_DONE   = 6'b100000
	} state_t;

	state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		cmd      = '0;
		state_nx = state_q;
		case (state_q)
			S_INIT: begin
				cmd.sweep_run = 1'b1;
				if (stat.sweep_last) begin
					state_nx = S_IDLE;
				end
			end
			S_IDLE: begin
				cmd.in_ready = 1'b1;
				if (in_valid) begin
					cmd.take_in = 1'b1;
					state_nx    = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				if (stat.func == FUNC_CLEAR) begin
					cmd.fill_go = 1'b1;
					state_nx    = S_FILL;
				end else if (stat.need_scroll) begin
					cmd.scroll_go = 1'b1;
					state_nx      = S_SCROLL;
				end else begin
					state_nx = S_DONE;
				end
			end
			S_SCROLL, S_FILL: begin
				cmd.sweep_run = 1'b1;
				if (stat.sweep_last) begin
					state_nx = S_DONE;
				end
			end
			S_DONE: begin
				// hold the result until the output register can take it
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					cmd.in_ready = 1'b1;
					if (in_valid) begin
						cmd.take_in = 1'b1;
						state_nx    = S_EXEC;
					end else begin
						state_nx = S_IDLE;
					end
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

endmodule

// ===== design/ctw_dpath.sv =====
`timescale 1ns / 1ps
module ctw_dpath import ctw_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  ctw_cmd_t           cmd,
	output ctw_stat_t          stat,
	input  logic [FUNC_FW-1:0] in_func,
	input  logic [CHAR_FW-1:0] in_char,
	input  logic [IDX_FW-1:0]  in_idx,
	input  logic               cfg_we,
	input  logic [ATTR_FW-1:0] cfg_wdata,
	ctw_rsp_if.source          rsp
);

	logic [2*CHAR_FW-1:0] mem [CELLS];
	logic [2*CHAR_FW-1:0] mem_rd_q;

	func_t               func_q;
	logic [CHAR_FW-1:0]  ch_q;
	logic [IDX_FW-1:0]   idx_q;
	logic [ATTR_FW-1:0]  attr_q;
	logic [ATTR_FW-1:0]  fill_attr_q;
	logic                mode_scroll_q;
	logic [ADDR_W-1:0]   cnt_q;

	logic [COL_W-1:0]    col_q, n_col;
	logic [ROW_W-1:0]    row_q, n_row;
	logic [ADDR_W-1:0]   pos_q, n_pos, pos_base;
	logic                scrolled_q;
	logic                read_hit_q;
	logic [SUM_W-1:0]    tab_col;
	logic                adv_row;
	logic                need_scroll;
	logic                is_print;
	logic                read_hit;

	logic                vld_s1, copy_s1;
	logic [ADDR_W-1:0]   addr_s1;

	logic                copy_now;
	logic [ADDR_W:0]     src_addr;

	logic                we, re;
	logic [ADDR_W-1:0]   wr_addr, rd_addr;
	logic [2*CHAR_FW-1:0] wr_data;

	logic                out_valid_q;
	logic [POS_FW-1:0]   out_pos_q;
	logic [COL_FW-1:0]   out_col_q;
	logic [ROW_FW-1:0]   out_row_q;
	logic                out_scr_q;
	logic [CHAR_FW-1:0]  out_char_q;
	logic [ATTR_FW-1:0]  out_attr_q;

	// Next cursor for the latched request
	assign pos_base = pos_q - ADDR_W'(col_q);
	assign tab_col  = SUM_W'(col_q) + SUM_W'(TAB_WIDTH) - SUM_W'(col_q % TAB_WIDTH);
	assign is_print = (ch_q != CH_TAB) && (ch_q != CH_LF) && (ch_q != CH_CR);
	assign read_hit = (ADDR_W + 1)'(idx_q) < (ADDR_W + 1)'(CELLS);

	always_comb begin
		n_col   = col_q;
		n_row   = row_q;
		n_pos   = pos_q;
		adv_row = 1'b0;
		case (func_q)
			FUNC_PUT: begin
				if (ch_q == CH_TAB) begin
					if (tab_col >= SUM_W'(COLUMNS)) begin
						adv_row = 1'b1;
						n_col   = COL_W'(tab_col - SUM_W'(COLUMNS));
					end else begin
						n_col = COL_W'(tab_col);
					end
					n_pos = pos_base + ADDR_W'(tab_col);
				end else if (ch_q == CH_LF) begin
					adv_row = 1'b1;
					n_col   = '0;
					n_pos   = pos_base + ADDR_W'(COLUMNS);
				end else if (ch_q == CH_CR) begin
					n_col = '0;
					n_pos = pos_base;
				end else begin
					if (col_q == COL_W'(COLUMNS - 1)) begin
						adv_row = 1'b1;
						n_col   = '0;
					end else begin
						n_col = col_q + 1'b1;
					end
					n_pos = pos_q + 1'b1;
				end
				if (adv_row) begin
					n_row = row_q + 1'b1;
				end
			end
			FUNC_BKSP: begin
				if (col_q != '0) begin
					n_col = col_q - 1'b1;
					n_pos = pos_q - 1'b1;
				end
			end
			FUNC_CLEAR: begin
				n_col = '0;
				n_row = '0;
				n_pos = '0;
			end
			default: begin
			end
		endcase
		need_scroll = adv_row && (row_q == ROW_W'(ROWS - 1));
		if (need_scroll) begin
			n_col = '0;
			n_row = ROW_W'(ROWS - 1);
			n_pos = ADDR_W'((ROWS - 1) * COLUMNS);
		end
	end

	// Sweep source: scroll copies from one row below
	assign copy_now = cnt_q < ADDR_W'(CELLS - COLUMNS);
	assign src_addr = (ADDR_W + 1)'(cnt_q) + (ADDR_W + 1)'(COLUMNS);

	always_comb begin
		we      = 1'b0;
		wr_addr = pos_q;
		wr_data = {attr_q, ch_q};
		if (vld_s1) begin
			we      = 1'b1;
			wr_addr = addr_s1;
			wr_data = copy_s1 ? mem_rd_q : {{ATTR_FW{1'b0}}, CH_SPACE};
		end else if (cmd.sweep_run && !mode_scroll_q) begin
			we      = 1'b1;
			wr_addr = cnt_q;
			wr_data = {fill_attr_q, CH_SPACE};
		end else if (cmd.exec && func_q == FUNC_PUT && is_print) begin
			we      = 1'b1;
			wr_addr = pos_q;
			wr_data = {attr_q, ch_q};
		end else if (cmd.exec && func_q == FUNC_BKSP) begin
			we      = 1'b1;
			wr_addr = n_pos;
			wr_data = {attr_q, CH_SPACE};
		end
	end

	always_comb begin
		re      = 1'b0;
		rd_addr = ADDR_W'(idx_q);
		if (cmd.sweep_run && mode_scroll_q && copy_now) begin
			re      = 1'b1;
			rd_addr = ADDR_W'(src_addr);
		end else if (cmd.exec && func_q == FUNC_READ && read_hit) begin
			re = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
		if (re) begin
			mem_rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take_in) begin
			func_q <= func_t'(in_func);
			ch_q   <= in_char;
			idx_q  <= in_idx;
		end
		if (cmd.sweep_run && mode_scroll_q) begin
			addr_s1 <= cnt_q;
			copy_s1 <= copy_now;
		end
		if (cmd.load_out) begin
			out_pos_q  <= POS_FW'(pos_q);
			out_col_q  <= COL_FW'(col_q);
			out_row_q  <= ROW_FW'(row_q);
			out_scr_q  <= scrolled_q;
			out_char_q <= read_hit_q ? mem_rd_q[CHAR_FW-1:0] : '0;
			out_attr_q <= read_hit_q ? mem_rd_q[2*CHAR_FW-1:CHAR_FW] : '0;
		end
		if (cmd.exec) begin
			scrolled_q <= need_scroll;
			read_hit_q <= (func_q == FUNC_READ) && read_hit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q        <= RESET_ATTR;
			fill_attr_q   <= RESET_ATTR;
			mode_scroll_q <= 1'b0;
			cnt_q         <= '0;
			vld_s1        <= 1'b0;
			col_q         <= '0;
			row_q         <= '0;
			pos_q         <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				attr_q <= cfg_wdata;
			end
			vld_s1 <= cmd.sweep_run && mode_scroll_q;
			if (cmd.fill_go) begin
				mode_scroll_q <= 1'b0;
				fill_attr_q   <= attr_q;
				cnt_q         <= '0;
			end else if (cmd.scroll_go) begin
				mode_scroll_q <= 1'b1;
				cnt_q         <= '0;
			end else if (cmd.sweep_run) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.exec) begin
				col_q <= n_col;
				row_q <= n_row;
				pos_q <= n_pos;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign stat.func        = func_q;
	assign stat.need_scroll = need_scroll;
	assign stat.sweep_last  = cnt_q == ADDR_W'(CELLS - 1);
	assign stat.out_free    = !out_valid_q || rsp.ready;

	assign rsp.valid      = out_valid_q;
	assign rsp.cursor_pos = out_pos_q;
	assign rsp.cursor_col = out_col_q;
	assign rsp.cursor_row = out_row_q;
	assign rsp.scrolled   = out_scr_q;
	assign rsp.read_char  = out_char_q;
	assign rsp.read_attr  = out_attr_q;

endmodule

// ===== design/text_mode_console_writer.sv =====
`timescale 1ns / 1ps
// Text console engine: a 25 x 80 screen of character/attribute cells and a cursor.
// req carries one request (func, char_code, cell_index) under valid/ready; rsp
// returns one result per request (cursor after the step, scroll flag, read cell).
// cfg_we/cfg_wdata write the text attribute at any clock edge; it applies from
// the next request on.
// Sequence: put character, backspace and read latch the request, execute it and
// load the result into the output register; the next request can be taken as a
// result is loaded while the receiver keeps up. A clear sweeps all 2000 cells,
// one write a cycle. A put that runs past the last row scrolls: the sweep
// reads one cell and writes one cell a cycle through the screen memory's read
// and write ports.
// Reset: the screen is filled with spaces in attribute 0x0F while req.ready
// stays low; the cursor goes home.
// Stall: a result waits in the output register while rsp.ready is low; one
// further request may be taken and worked, and its result is held until the
// output register frees up.
module text_mode_console_writer import ctw_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	ctw_req_if.sink            req,
	ctw_rsp_if.source          rsp,
	input  logic               cfg_we,
	input  logic [ATTR_FW-1:0] cfg_wdata
);

	ctw_cmd_t  cmd;
	ctw_stat_t stat;

	assign req.ready = cmd.in_ready;

	ctw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.stat     (stat),
		.cmd      (cmd)
	);

	ctw_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.in_func   (req.func),
		.in_char   (req.char_code),
		.in_idx    (req.cell_index),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.rsp       (rsp)
	);

endmodule

// ===== tb/ctw_console_checker.sv =====
`timescale 1ns / 1ps
module ctw_console_checker import ctw_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	ctw_req_if                 req,
	ctw_rsp_if                 rsp,
	input  logic               cfg_we,
	input  logic [ATTR_FW-1:0] cfg_wdata,
	output int                 fail_count,
	output int                 pending
);

	typedef struct packed {
		logic [POS_FW-1:0]  pos;
		logic [COL_FW-1:0]  col;
		logic [ROW_FW-1:0]  row;
		logic               scrolled;
		logic [CHAR_FW-1:0] rchar;
		logic [ATTR_FW-1:0] rattr;
	} console_result_t;

	// cell layout: attribute in the high byte, character in the low byte
	logic [15:0]        screen [CELLS];
	int                 cursor;
	logic [ATTR_FW-1:0] text_attr;
	console_result_t    awaited_results [$];

	// Move the cursor; past the last row shift the screen up and blank the bottom row.
	function automatic logic move_cursor_to(int target);
		int i;
		if (target / COLUMNS >= ROWS) begin
			for (i = 0; i < CELLS - COLUMNS; i++)
				screen[i] = screen[i + COLUMNS];
			for (i = CELLS - COLUMNS; i < CELLS; i++)
				screen[i] = {8'h00, CH_SPACE};
			cursor = (ROWS - 1) * COLUMNS;
			return 1'b1;
		end
		cursor = target;
		return 1'b0;
	endfunction

	function automatic console_result_t console_step(func_t f, logic [CHAR_FW-1:0] ch,
			logic [IDX_FW-1:0] idx);
		console_result_t r;
		int              col;
		int              row;
		int              i;
		logic            scr;
		r   = '0;
		scr = 1'b0;
		col = cursor % COLUMNS;
		row = cursor / COLUMNS;
		case (f)
			FUNC_PUT: begin
				if (ch == CH_TAB)
					scr = move_cursor_to(row * COLUMNS + col + TAB_WIDTH - (col % TAB_WIDTH));
				else if (ch == CH_LF)
					scr = move_cursor_to((row + 1) * COLUMNS);
				else if (ch == CH_CR)
					scr = move_cursor_to(row * COLUMNS);
				else begin
					screen[cursor] = {text_attr, ch};
					scr = move_cursor_to(cursor + 1);
				end
			end
			FUNC_BKSP: begin
				if (col != 0)
					col--;
				cursor = row * COLUMNS + col;
				screen[cursor] = {text_attr, CH_SPACE};
			end
			FUNC_CLEAR: begin
				for (i = 0; i < CELLS; i++)
					screen[i] = {text_attr, CH_SPACE};
				cursor = 0;
			end
			FUNC_READ: begin
				if (int'(idx) < CELLS) begin
					r.rchar = screen[idx][7:0];
					r.rattr = screen[idx][15:8];
				end
			end
			default: ;
		endcase
		r.pos      = POS_FW'(cursor);
		r.col      = COL_FW'(cursor % COLUMNS);
		r.row      = ROW_FW'(cursor / COLUMNS);
		r.scrolled = scr;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		console_result_t exp_r;
		console_result_t got_r;
		int              i;
		if (!arst_n) begin
			for (i = 0; i < CELLS; i++)
				screen[i] = {RESET_ATTR, CH_SPACE};
			cursor    = 0;
			text_attr = RESET_ATTR;
			awaited_results.delete();
			pending = 0;
		end else begin
			if (cfg_we)
				text_attr = cfg_wdata;
			if (rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
				got_r = {rsp.cursor_pos, rsp.cursor_col, rsp.cursor_row, rsp.scrolled,
					rsp.read_char, rsp.read_attr};
				if (awaited_results.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%0t: result with none awaited: pos=%0d col=%0d row=%0d",
							$realtime, got_r.pos, got_r.col, got_r.row);
				end else begin
					exp_r = awaited_results.pop_front();
					if (got_r.pos !== exp_r.pos || got_r.col !== exp_r.col ||
							got_r.row !== exp_r.row || got_r.scrolled !== exp_r.scrolled ||
							got_r.rchar !== exp_r.rchar || got_r.rattr !== exp_r.rattr) begin
						fail_count++;
						if (fail_count <= 10) begin
							$display("%0t: mismatch exp pos=%0d col=%0d row=%0d scr=%0b ch=%02h at=%02h",
								$realtime, exp_r.pos, exp_r.col, exp_r.row, exp_r.scrolled,
								exp_r.rchar, exp_r.rattr);
							$display("%0t:          got pos=%0d col=%0d row=%0d scr=%0b ch=%02h at=%02h",
								$realtime, got_r.pos, got_r.col, got_r.row, got_r.scrolled,
								got_r.rchar, got_r.rattr);
						end
					end
				end
			end
			if (req.valid === 1'b1 && req.ready === 1'b1)
				awaited_results.push_back(console_step(func_t'(req.func), req.char_code,
					req.cell_index));
			pending = awaited_results.size();
		end
	end

endmodule

// ===== tb/tb_text_mode_console_writer.sv =====
`timescale 1ns / 1ps
module tb_text_mode_console_writer;
	import ctw_pkg::*;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [ATTR_FW-1:0] cfg_wdata;
	int                 fail_count;
	int                 pending;
	logic               tx_calm;
	logic               rx_calm;

	ctw_req_if req_ch ();
	ctw_rsp_if rsp_ch ();

	text_mode_console_writer u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	ctw_console_checker u_console_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req_ch),
		.rsp        (rsp_ch),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Called at a falling edge; returns at the falling edge after the request is taken.
	task automatic send_request(func_t f, logic [CHAR_FW-1:0] ch, logic [IDX_FW-1:0] idx);
		int gap;
		gap = tx_calm ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid      <= 1'b1;
		req_ch.func       <= f;
		req_ch.char_code  <= ch;
		req_ch.cell_index <= idx;
		do @(posedge clk); while (!(req_ch.valid === 1'b1 && req_ch.ready === 1'b1));
		@(negedge clk);
	endtask

	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	task automatic write_attr(logic [ATTR_FW-1:0] value);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	function automatic logic [CHAR_FW-1:0] text_byte();
		if ($urandom_range(0, 7) == 0)
			return CHAR_FW'($urandom);
		return CHAR_FW'($urandom_range(8'h20, 8'h7E));
	endfunction

	function automatic logic [IDX_FW-1:0] read_addr();
		case ($urandom_range(0, 9))
			0:       return IDX_FW'($urandom_range(CELLS, 2047));
			1, 2:    return IDX_FW'($urandom_range(CELLS - COLUMNS, CELLS - 1));
			default: return IDX_FW'($urandom_range(0, CELLS - 1));
		endcase
	endfunction

	// Bursts of well-formed text and cursor motion, with a little noise mixed in.
	task automatic run_console_phase(int budget);
		int sent;
		int kind;
		int n;
		int k;
		sent = 0;
		while (sent < budget) begin
			kind    = $urandom_range(0, 99);
			tx_calm = ($urandom_range(0, 4) == 0);
			if (kind < 35) begin
				n = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 100) : $urandom_range(1, 20);
				for (k = 0; k < n; k++)
					send_request(FUNC_PUT, text_byte(), IDX_FW'($urandom));
			end else if (kind < 50) begin
				n = $urandom_range(1, 12);
				for (k = 0; k < n; k++)
					send_request(FUNC_PUT, CH_LF, IDX_FW'($urandom));
			end else if (kind < 58) begin
				n = $urandom_range(1, 24);
				for (k = 0; k < n; k++)
					send_request(FUNC_PUT, CH_TAB, IDX_FW'($urandom));
			end else if (kind < 66) begin
				n = 1;
				send_request(FUNC_PUT, CH_CR, IDX_FW'($urandom));
				if ($urandom_range(0, 1) == 1) begin
					send_request(FUNC_PUT, CH_LF, IDX_FW'($urandom));
					n = 2;
				end
			end else if (kind < 76) begin
				n = $urandom_range(1, 6);
				for (k = 0; k < n; k++)
					send_request(FUNC_BKSP, CHAR_FW'($urandom), IDX_FW'($urandom));
			end else if (kind < 88) begin
				n = $urandom_range(1, 6);
				for (k = 0; k < n; k++)
					send_request(FUNC_READ, CHAR_FW'($urandom), read_addr());
			end else if (kind < 91) begin
				n = 1;
				send_request(FUNC_CLEAR, CHAR_FW'($urandom), IDX_FW'($urandom));
			end else begin
				n = $urandom_range(1, 4);
				for (k = 0; k < n; k++)
					send_request(func_t'($urandom_range(0, 3)), CHAR_FW'($urandom),
						IDX_FW'($urandom));
			end
			sent += n;
		end
	endtask

	// Result side: random stalls, with calm stretches every few dozen results.
	initial begin
		int stall;
		int taken;
		rsp_ch.ready = 1'b0;
		rx_calm      = 1'b0;
		taken        = 0;
		forever begin
			@(negedge clk);
			stall = rx_calm ? 0 : $urandom_range(0, 8);
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!(rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1));
			taken++;
			if (taken % 32 == 0)
				rx_calm = ($urandom_range(0, 2) == 0);
		end
	end

	initial begin
		logic [ATTR_FW-1:0] attr_plan [6];
		int                 p;
		arst_n            = 1'b0;
		cfg_we            = 1'b0;
		cfg_wdata         = '0;
		tx_calm           = 1'b0;
		req_ch.valid      = 1'b0;
		req_ch.func       = FUNC_PUT;
		req_ch.char_code  = '0;
		req_ch.cell_index = '0;
		attr_plan = '{8'hFF, 8'h00, 8'h00, 8'hA5, 8'h5A, 8'h00};
		attr_plan[2] = ATTR_FW'($urandom);
		attr_plan[5] = ATTR_FW'($urandom);
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: reset contents, range edges, each operation and cursor motion
		send_request(FUNC_READ, 8'h00, 11'd0);
		send_request(FUNC_READ, 8'hFF, 11'd1999);
		send_request(FUNC_READ, 8'h00, 11'd2000);
		send_request(FUNC_READ, 8'hFF, 11'd2047);
		send_request(FUNC_BKSP, 8'h00, 11'd0);
		send_request(FUNC_PUT, 8'h41, 11'd2047);
		send_request(FUNC_PUT, 8'hFF, 11'd0);
		send_request(FUNC_PUT, 8'h00, 11'd0);
		send_request(FUNC_PUT, CH_TAB, 11'd0);
		send_request(FUNC_PUT, CH_CR, 11'd0);
		send_request(FUNC_PUT, CH_TAB, 11'd0);
		send_request(FUNC_BKSP, 8'h00, 11'd0);
		send_request(FUNC_PUT, CH_LF, 11'd0);
		send_request(FUNC_READ, 8'h00, 11'd1);
		send_request(FUNC_READ, 8'h00, 11'd2);
		send_request(FUNC_READ, 8'h00, 11'd3);
		send_request(FUNC_CLEAR, 8'h00, 11'd0);
		send_request(FUNC_READ, 8'h00, 11'd0);
		send_request(FUNC_PUT, CH_SPACE, 11'd0);
		send_request(FUNC_BKSP, 8'h00, 11'd0);
		send_request(FUNC_READ, 8'h00, 11'd80);

		for (p = 0; p < 6; p++) begin
			wait_drained();
			write_attr(attr_plan[p]);
			run_console_phase(92);
		end

		wait_drained();
		repeat (50) @(negedge clk);
		if (fail_count == 0)
			$display("tb_text_mode_console_writer: clean");
		else
			$display("tb_text_mode_console_writer: errors");
		$finish;
	end

	initial begin
		#50_000_000;
		$display("tb_text_mode_console_writer: errors");
		$finish;
	end

endmodule
